>>> rtl/core/raf_pkg.sv
// Package for the record admission ring FIFO.
// Holds the sizing constants and the payload and queue entry types.
// Depends on nothing; every other RTL file refers to it by scoped name.
`default_nettype none

package raf_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned LEN_W       = PTR_W + 1;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DROP_W      = 16;
  localparam int unsigned USED_W      = 8;
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  // Item kinds carried in the mode field.
  localparam logic MODE_RECORD  = 1'b0;
  localparam logic MODE_SERVICE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              mailbox_empty;
  } raf_in_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              record_done;
    logic              record_accepted;
    logic [DROP_W-1:0] dropped_records;
    logic [USED_W-1:0] queue_used;
  } raf_out_t;

  // A classified word as it waits between the front and the back.
  typedef struct packed {
    logic              service;
    logic              term;
    logic              enable;
    logic              mailbox_empty;
    logic [BYTE_W-1:0] data_byte;
  } raf_cmd_t;

  typedef struct packed {
    logic     valid;
    raf_cmd_t cmd;
  } raf_push_t;

  typedef struct packed {
    logic     valid;
    raf_cmd_t cmd;
  } raf_head_t;

endpackage

`default_nettype wire

>>> rtl/core/raf_front.sv
// Front end of the record admission ring FIFO: input handshake, enable
// register and classification of each word. Uses raf_pkg.
`default_nettype none

module raf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire raf_pkg::raf_in_t  in_payload,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              q_full,
  output raf_pkg::raf_push_t     push
);

  logic enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;

  always_comb begin
    push.valid             = in_valid && !q_full;
    push.cmd.service       = (in_payload.mode == raf_pkg::MODE_SERVICE);
    push.cmd.term          = (in_payload.data_byte == '0);
    push.cmd.enable        = enable_r;
    push.cmd.mailbox_empty = in_payload.mailbox_empty;
    push.cmd.data_byte     = in_payload.data_byte;
  end

endmodule

`default_nettype wire

>>> rtl/core/raf_cmdq.sv
// Short command queue that decouples the front end from the back end.
// Two entries, push and pop in the same cycle allowed. Uses raf_pkg.
`default_nettype none

module raf_cmdq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire raf_pkg::raf_push_t push,
  output logic                    full,
  output raf_pkg::raf_head_t      head,
  input  wire logic               pop
);

  raf_pkg::raf_cmd_t                    slot_r [raf_pkg::CMDQ_DEPTH];
  logic [raf_pkg::CMDQ_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [raf_pkg::CMDQ_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [raf_pkg::CMDQ_CNT_W-1:0]       count_r, count_nxt;
  logic                                 do_pop;

  assign full     = (count_r == raf_pkg::CMDQ_CNT_W'(raf_pkg::CMDQ_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/raf_back.sv
// Back end of the record admission ring FIFO: ring pointers, record staging,
// the byte store and the two result stages. Uses raf_pkg.
`default_nettype none

module raf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire raf_pkg::raf_head_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output raf_pkg::raf_out_t       out_payload
);

  logic [raf_pkg::BYTE_W-1:0] mem [raf_pkg::QUEUE_DEPTH];
  logic [raf_pkg::BYTE_W-1:0] rd_q;

  logic [raf_pkg::PTR_W-1:0]  read_ptr_r, read_ptr_nxt;
  logic [raf_pkg::PTR_W-1:0]  commit_ptr_r, commit_ptr_nxt;
  logic [raf_pkg::PTR_W-1:0]  stage_ptr_r, stage_ptr_nxt;
  logic [raf_pkg::LEN_W-1:0]  record_len_r, record_len_nxt;
  logic [raf_pkg::PTR_W-1:0]  space_r, space_nxt;
  logic                       overflow_r, overflow_nxt;
  logic [raf_pkg::DROP_W-1:0] drop_r, drop_nxt;

  logic                       fire;
  logic                       rd_en;
  logic                       wr_en;
  logic                       start;
  logic [raf_pkg::PTR_W-1:0]  snap;
  logic [raf_pkg::PTR_W-1:0]  sp;
  logic                       done;
  logic                       accepted;
  logic [raf_pkg::PTR_W-1:0]  used;

  // Result stage waiting for the store read data, then the output register.
  logic                       pend_v_r, pend_v_nxt;
  logic                       pend_tx_r;
  logic                       pend_done_r;
  logic                       pend_acc_r;
  logic [raf_pkg::DROP_W-1:0] pend_drop_r;
  logic [raf_pkg::USED_W-1:0] pend_used_r;
  logic                       pend_move;
  logic                       out_v_r, out_v_nxt;
  raf_pkg::raf_out_t          out_r;

  assign pend_move = pend_v_r && (!out_v_r || !out_stall);
  assign fire      = head.valid && (!pend_v_r || pend_move);
  assign pop       = fire;

  always_comb begin
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    stage_ptr_nxt  = stage_ptr_r;
    record_len_nxt = record_len_r;
    space_nxt      = space_r;
    overflow_nxt   = overflow_r;
    drop_nxt       = drop_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    done           = 1'b0;
    accepted       = 1'b0;
    start          = (record_len_r == '0) && !overflow_r;
    snap           = start ? (read_ptr_r - commit_ptr_r - 1'b1) : space_r;
    sp             = start ? commit_ptr_r : stage_ptr_r;
    if (fire) begin
      if (head.cmd.service) begin
        if (head.cmd.enable && head.cmd.mailbox_empty && (read_ptr_r != commit_ptr_r)) begin
          rd_en        = 1'b1;
          read_ptr_nxt = read_ptr_r + 1'b1;
        end
      end else if (!head.cmd.enable) begin
        // A disabled record word abandons any record in progress uncounted.
        record_len_nxt = '0;
        overflow_nxt   = 1'b0;
        done           = head.cmd.term;
      end else begin
        space_nxt     = snap;
        stage_ptr_nxt = sp;
        if (head.cmd.term) begin
          done = 1'b1;
          if (overflow_r) begin
            drop_nxt = drop_r + 1'b1;
          end else begin
            commit_ptr_nxt = sp;
            accepted       = 1'b1;
          end
          record_len_nxt = '0;
          overflow_nxt   = 1'b0;
        end else if (record_len_r >= {1'b0, snap}) begin
          overflow_nxt = 1'b1;
        end else begin
          wr_en          = 1'b1;
          stage_ptr_nxt  = sp + 1'b1;
          record_len_nxt = record_len_r + 1'b1;
        end
      end
    end
    used = commit_ptr_nxt - read_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      stage_ptr_r  <= '0;
      record_len_r <= '0;
      space_r      <= '0;
      overflow_r   <= 1'b0;
      drop_r       <= '0;
    end else begin
      read_ptr_r   <= read_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      stage_ptr_r  <= stage_ptr_nxt;
      record_len_r <= record_len_nxt;
      space_r      <= space_nxt;
      overflow_r   <= overflow_nxt;
      drop_r       <= drop_nxt;
    end
  end

  // Staged bytes never share an address with unread committed bytes, so the
  // write and read ports never collide on one entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sp] <= head.cmd.data_byte;
    end
    if (rd_en) begin
      rd_q <= mem[read_ptr_r];
    end
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (fire) begin
      pend_v_nxt = 1'b1;
    end else if (pend_move) begin
      pend_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (pend_move) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_tx_r   <= rd_en;
      pend_done_r <= done;
      pend_acc_r  <= accepted;
      pend_drop_r <= drop_nxt;
      pend_used_r <= raf_pkg::USED_W'(used);
    end
    // rd_q only changes when a new word fires, and that happens no earlier
    // than the edge at which the waiting word leaves, so it is still valid here.
    if (pend_move) begin
      out_r.tx_valid        <= pend_tx_r;
      out_r.tx_byte         <= pend_tx_r ? rd_q : '0;
      out_r.record_done     <= pend_done_r;
      out_r.record_accepted <= pend_acc_r;
      out_r.dropped_records <= pend_drop_r;
      out_r.queue_used      <= pend_used_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

>>> rtl/core/record_admit_ring_fifo.sv
// Record admission ring FIFO: a byte ring buffer that admits whole
// zero-terminated records and drains one byte per service word.
// Top level; instantiates raf_front, raf_cmdq and raf_back, uses raf_pkg.
//
// Input words carry a mode bit: a record byte (zero ends the record) or a
// service tick that moves one committed byte into the mailbox when the
// consumer's mailbox is empty. Every input word gives exactly one result
// word, in order. A record is committed whole at its terminator if it fitted
// in the free space seen at its first byte; otherwise it is dropped and the
// 16-bit drop counter advances. Clearing cfg_wdata through cfg_we stops
// draining and rejects records without counting them.
// Throughput is one word per cycle while the receiver does not stall; each
// word makes the pointer update and at most one store access in the back end.
// A result passes in turn through the command queue, the store read stage and
// the output register. When the receiver stalls, the output register, the read
// stage and the two-entry command queue fill up in turn before in_stall rises.
// Reset clears the pointers, the record state, the drop counter and sets
// enable; the byte store itself is not cleared, as only written entries are
// ever read.
`default_nettype none

module record_admit_ring_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire raf_pkg::raf_in_t  in_payload,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output raf_pkg::raf_out_t      out_payload,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata
);

  raf_pkg::raf_push_t push;
  raf_pkg::raf_head_t head;
  logic               q_full;
  logic               pop;

  raf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_full     (q_full),
    .push       (push)
  );

  raf_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  raf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

>>> rtl/core/raf_checker.sv
// Port-level checker for the record admission ring FIFO, bound to the top
// level. Uses raf_pkg for the payload type.
`default_nettype none

module raf_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire raf_pkg::raf_out_t out_payload
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("stalled result word changed or vanished");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.tx_valid |-> out_payload.tx_byte == '0)
    else $error("mailbox byte nonzero without a transfer");

  a_accept_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.record_accepted |-> out_payload.record_done)
    else $error("record accepted on a word that was no terminator");

  a_tx_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.tx_valid |-> !out_payload.record_done)
    else $error("one word both drained a byte and ended a record");

endmodule

bind record_admit_ring_fifo raf_checker u_raf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

`default_nettype wire

>>> tb/raf_result_checker.sv
// Result checker for the record admission ring FIFO testbench.
// Watches both channels and the enable write, predicts each result word and
// compares it field by field; uses raf_pkg for the payload types.
module raf_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  raf_pkg::raf_in_t              in_payload,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  raf_pkg::raf_out_t             out_payload,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  output int                            pending_words,
  output int                            fail_count,
  output logic [raf_pkg::USED_W-1:0]    used_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted block state.
  logic [raf_pkg::BYTE_W-1:0] ring [raf_pkg::QUEUE_DEPTH];
  logic [raf_pkg::PTR_W-1:0]  rd_ptr;
  logic [raf_pkg::PTR_W-1:0]  commit_ptr;
  logic [raf_pkg::PTR_W-1:0]  stage_ptr;
  logic [raf_pkg::LEN_W-1:0]  rec_len;
  logic [raf_pkg::PTR_W-1:0]  budget;
  logic                       overflow;
  logic [raf_pkg::DROP_W-1:0] drops;
  logic                       enabled;

  raf_pkg::raf_out_t awaited_results [$];
  int errors = 0;
  int result_idx = 0;

  initial begin
    pending_words = 0;
    fail_count = 0;
    used_words = '0;
  end

  task note_mismatch(input string field, input logic [raf_pkg::DROP_W-1:0] got,
                     input logic [raf_pkg::DROP_W-1:0] want);
    errors++;
    $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
             result_idx, field, got, want);
  endtask

  // Applies one accepted input word to the predicted state and returns the
  // result word the block should produce for it.
  function raf_pkg::raf_out_t admit_or_drain(input raf_pkg::raf_in_t w);
    raf_pkg::raf_out_t r;
    r = '0;
    if (w.mode == raf_pkg::MODE_SERVICE) begin
      if (enabled && w.mailbox_empty && rd_ptr != commit_ptr) begin
        r.tx_valid = 1'b1;
        r.tx_byte = ring[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
      end
    end else if (!enabled) begin
      // A disabled record word abandons whatever record was being staged.
      rec_len = '0;
      overflow = 1'b0;
      r.record_done = (w.data_byte == '0);
    end else begin
      if (rec_len == '0 && !overflow) begin
        budget = rd_ptr - commit_ptr - 1'b1;
        stage_ptr = commit_ptr;
      end
      if (w.data_byte == '0) begin
        r.record_done = 1'b1;
        if (overflow) begin
          drops = drops + 1'b1;
        end else begin
          commit_ptr = stage_ptr;
          r.record_accepted = 1'b1;
        end
        rec_len = '0;
        overflow = 1'b0;
      end else if (rec_len >= budget) begin
        overflow = 1'b1;
      end else begin
        ring[stage_ptr] = w.data_byte;
        stage_ptr = stage_ptr + 1'b1;
        rec_len = rec_len + 1'b1;
      end
    end
    r.dropped_records = drops;
    r.queue_used = commit_ptr - rd_ptr;
    return r;
  endfunction

  always @(posedge clk) begin
    raf_pkg::raf_out_t want;
    if (!rst_n) begin
      rd_ptr = '0;
      commit_ptr = '0;
      stage_ptr = '0;
      rec_len = '0;
      budget = '0;
      overflow = 1'b0;
      drops = '0;
      enabled = 1'b1;
      awaited_results.delete();
    end else begin
      if (cfg_we) enabled = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("unexpected result word", '0, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_payload.tx_valid !== want.tx_valid)
            note_mismatch("tx_valid", raf_pkg::DROP_W'(out_payload.tx_valid),
                          raf_pkg::DROP_W'(want.tx_valid));
          if (out_payload.tx_byte !== want.tx_byte)
            note_mismatch("tx_byte", raf_pkg::DROP_W'(out_payload.tx_byte),
                          raf_pkg::DROP_W'(want.tx_byte));
          if (out_payload.record_done !== want.record_done)
            note_mismatch("record_done", raf_pkg::DROP_W'(out_payload.record_done),
                          raf_pkg::DROP_W'(want.record_done));
          if (out_payload.record_accepted !== want.record_accepted)
            note_mismatch("record_accepted",
                          raf_pkg::DROP_W'(out_payload.record_accepted),
                          raf_pkg::DROP_W'(want.record_accepted));
          if (out_payload.dropped_records !== want.dropped_records)
            note_mismatch("dropped_records", out_payload.dropped_records,
                          want.dropped_records);
          if (out_payload.queue_used !== want.queue_used)
            note_mismatch("queue_used", raf_pkg::DROP_W'(out_payload.queue_used),
                          raf_pkg::DROP_W'(want.queue_used));
        end
        result_idx++;
      end
      if (in_valid && !in_stall) awaited_results.push_back(admit_or_drain(in_payload));
    end
    pending_words <= awaited_results.size();
    fail_count <= errors;
    used_words <= commit_ptr - rd_ptr;
  end

endmodule

>>> tb/tb.sv
// Testbench top for the record admission ring FIFO.
// Drives record and service words, the enable register and receiver stalls;
// checking is done by raf_result_checker. Uses raf_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  raf_pkg::raf_in_t  in_payload = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  raf_pkg::raf_out_t out_payload;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  int pending_words;
  int fail_count;
  logic [raf_pkg::USED_W-1:0] used_words;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  record_admit_ring_fifo uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  raf_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_payload    (in_payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_payload   (out_payload),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pending_words (pending_words),
    .fail_count    (fail_count),
    .used_words    (used_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when the toggle flips.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic offer_word(input logic mode, input logic [raf_pkg::BYTE_W-1:0] data,
                            input logic mbox);
    raf_pkg::raf_in_t w;
    w.mode = mode;
    w.data_byte = data;
    w.mailbox_empty = mbox;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // The checker's count is registered, so wait for an edge before looking at it.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic set_enable(input logic on);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed records with random content and lengths, service words
  // in between and inside records, and some noise and unterminated records.
  // A phase may end in the middle of a record.
  task automatic make_traffic(input int n, input int svc_pct);
    int sent;
    int len;
    int r;
    int i;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 6) begin
        offer_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
        sent++;
      end else if (r < 6 + svc_pct) begin
        offer_word(raf_pkg::MODE_SERVICE, 8'($urandom_range(255)),
                   $urandom_range(9) != 0);
        sent++;
      end else begin
        len = ($urandom_range(15) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 20);
        for (i = 0; i < len && sent < n; i++) begin
          if ($urandom_range(99) < svc_pct / 3) begin
            offer_word(raf_pkg::MODE_SERVICE, 8'($urandom_range(255)),
                       1'($urandom_range(1)));
            sent++;
          end
          offer_word(raf_pkg::MODE_RECORD, 8'($urandom_range(1, 255)),
                     1'($urandom_range(1)));
          sent++;
        end
        if (sent < n && $urandom_range(19) != 0) begin
          offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic en, input int idle, input int stall,
                           input int svc_pct, input int n);
    set_enable(en);
    idle_pct = idle;
    stall_pct = stall;
    make_traffic(n, svc_pct);
  endtask

  initial begin
    int drain_n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_enable(1'b1);

    // Directed words: empty queue, empty record, field extremes, a full
    // mailbox, service inside a record, and the disabled behaviour.
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b0);
    offer_word(raf_pkg::MODE_RECORD, 8'hFF, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h01, 1'b0);
    offer_word(raf_pkg::MODE_RECORD, 8'h80, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b0);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h7F, 1'b0);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'hAA, 1'b0);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b0);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h44, 1'b0);
    // One byte is still queued and a record is half staged when disabled.
    set_enable(1'b0);
    offer_word(raf_pkg::MODE_RECORD, 8'h12, 1'b0);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    set_enable(1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b0);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_SERVICE, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_SERVICE, 8'hFF, 1'b1);

    // Budget boundary: drain completely, then a record that exactly fills the
    // ring while the receiver holds off, a record with no room at all, and an
    // empty record into the full ring.
    wait_idle();
    drain_n = int'(used_words);
    repeat (drain_n) offer_word(raf_pkg::MODE_SERVICE, 8'($urandom_range(255)), 1'b1);
    hold_toggle <= ~hold_toggle;
    repeat (raf_pkg::QUEUE_DEPTH - 1)
      offer_word(raf_pkg::MODE_RECORD, 8'($urandom_range(1, 255)), 1'($urandom_range(1)));
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'($urandom_range(1, 255)), 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b1);
    offer_word(raf_pkg::MODE_RECORD, 8'h00, 1'b0);

    run_phase(1'b1, 0, 0, 35, 68);
    run_phase(1'b1, 76, 0, 8, 68);
    run_phase(1'b0, 0, 76, 30, 34);
    run_phase(1'b1, 26, 26, 8, 68);
    run_phase(1'b1, 0, 76, 10, 68);
    run_phase(1'b0, 76, 0, 30, 34);
    run_phase(1'b1, 26, 26, 70, 68);
    run_phase(1'b1, 0, 0, 40, 68);

    stall_pct = 0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
